>>> rtl/core/quad_view_grey_compositor_unit_macros.svh
// ----------------------------------------------------------------------------
// quad view grey compositor assertion macros
// shared assertion forms, clocked on clock and held off during reset
// ----------------------------------------------------------------------------
`ifndef QUAD_VIEW_GREY_COMPOSITOR_UNIT_MACROS_SVH
`define QUAD_VIEW_GREY_COMPOSITOR_UNIT_MACROS_SVH

// same-cycle implication
`define QVG_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QVG_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/qvg_pkg.sv
// ----------------------------------------------------------------------------
// qvg package
// widths, register indexes and shared types of the quad view compositor
// ----------------------------------------------------------------------------
package qvg_pkg;

   localparam int MAX_LINE_WIDTH  = 640;
   localparam int LINE_ADDR_WIDTH = $clog2(MAX_LINE_WIDTH);

   localparam int CHAN_WIDTH      = 8;
   localparam int PIXEL_WIDTH     = 3 * CHAN_WIDTH;
   localparam int SRC_WIDTH_BITS  = 10;
   localparam int SRC_HEIGHT_BITS = 11;
   localparam int COL_WIDTH       = SRC_WIDTH_BITS + 1;
   localparam int ROW_WIDTH       = SRC_HEIGHT_BITS + 1;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = SRC_HEIGHT_BITS;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_HEIGHT = 1'b1;

   localparam int WIDTH_RESET  = (640 > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : 640;
   localparam int HEIGHT_RESET = 480;

   // one output slot as decoded by the control stage
   typedef struct packed {
      logic                       left;
      logic [LINE_ADDR_WIDTH-1:0] line_addr;
      logic                       frame_start;
      logic                       line_end;
   } slot_type;

endpackage

>>> rtl/core/qvg_req_if.sv
// ----------------------------------------------------------------------------
// qvg request interface
// valid/ready channel carrying one source pixel word
// ----------------------------------------------------------------------------
interface qvg_req_if;
   import qvg_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAN_WIDTH-1:0] in_chan0;
   logic [CHAN_WIDTH-1:0] in_chan1;
   logic [CHAN_WIDTH-1:0] in_chan2;

   modport source (output valid, in_chan0, in_chan1, in_chan2, input ready);
   modport sink   (input valid, in_chan0, in_chan1, in_chan2, output ready);
endinterface

// ----------------------------------------------------------------------------
// qvg response interface
// valid/ready channel carrying one output pixel word with framing flags
// ----------------------------------------------------------------------------
interface qvg_rsp_if;
   import qvg_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAN_WIDTH-1:0] out_chan0;
   logic [CHAN_WIDTH-1:0] out_chan1;
   logic [CHAN_WIDTH-1:0] out_chan2;
   logic                  frame_start;
   logic                  line_end;

   modport source (output valid, out_chan0, out_chan1, out_chan2, frame_start, line_end,
                   input ready);
   modport sink   (input valid, out_chan0, out_chan1, out_chan2, frame_start, line_end,
                   output ready);
endinterface

>>> rtl/core/quad_view_grey_compositor_unit.sv
// ----------------------------------------------------------------------------
// quad view grey compositor unit
// 2x2 multiview builder with a grey right half and raster framing flags
// ----------------------------------------------------------------------------
// Each request word is one output pixel slot of a (2W x 2H) frame, in raster
// order. Left-half slots pass the supplied pixel straight through and keep it
// in a one-line store; right-half slots ignore the request data and emit the
// stored pixel of the matching column as grey (floor of the channel mean) on
// all three channels. Top rows carry camera A, bottom rows camera B. The unit
// takes one word per clock while the result side does not stall; an accepted
// word passes the registered line store read, then the result register.
// A write to either size register restarts the raster at row 0, column 0.
// The line store needs no clearing pass: every read follows a write of the
// same column earlier in the same line.
// ----------------------------------------------------------------------------
`include "quad_view_grey_compositor_unit_macros.svh"

module quad_view_grey_compositor_unit
   import qvg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   qvg_req_if.sink                    req_bus,
   qvg_rsp_if.source                  rsp_bus
);
   slot_type               slot;
   logic                   accept;
   logic                   slot_free;
   logic                   slot_stalled;
   logic [PIXEL_WIDTH-1:0] pixel;
   logic [PIXEL_WIDTH-1:0] store_data;

   // a word enters whenever the slot register is empty or draining
   assign req_bus.ready = slot_free;
   assign accept        = req_bus.valid && slot_free;
   assign pixel         = {req_bus.in_chan2, req_bus.in_chan1, req_bus.in_chan0};

   // raster position, size registers and slot decode
   qvg_slot_ctrl u_slot_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .slot             (slot)
   );

   // one source line; written in the left half, read in the right half,
   // untouched when no word enters so a stalled read stays put
   qvg_ram #(
      .DATA_WIDTH (PIXEL_WIDTH),
      .DEPTH      (MAX_LINE_WIDTH)
   ) u_line_store (
      .clock        (clock),
      .enable       (accept),
      .write_enable (slot.left),
      .address      (slot.line_addr),
      .write_data   (pixel),
      .read_data    (store_data)
   );

   // grey conversion and result register
   qvg_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .slot         (slot),
      .pixel        (pixel),
      .store_data   (store_data),
      .slot_free    (slot_free),
      .slot_stalled (slot_stalled),
      .rsp_bus      (rsp_bus)
   );

   // the first slot of a line can never also be its last
   `QVG_ASSERT_IMP(a_frame_start_not_line_end, rsp_bus.valid && rsp_bus.frame_start, !rsp_bus.line_end, "frame start word flagged as line end")

   // a held slot must see the same line store read data next cycle
   `QVG_ASSERT_NXT(a_store_read_held, slot_stalled, $stable(store_data), "line store read data changed under a stalled slot")

   // a result word waiting on the sink stays valid with its channel 0 unchanged
   `QVG_ASSERT_NXT(a_rsp_held, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid && $stable(rsp_bus.out_chan0), "result word dropped or changed while stalled")
endmodule

>>> rtl/core/qvg_ram.sv
// ----------------------------------------------------------------------------
// qvg single port ram
// generic one-port memory with registered read, read data held when idle or writing
// ----------------------------------------------------------------------------
module qvg_ram #(
   parameter int DATA_WIDTH = 24,
   parameter int DEPTH      = 640
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [DATA_WIDTH-1:0]    write_data,
   output logic [DATA_WIDTH-1:0]    read_data
);
   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         if (write_enable) begin
            mem_ff[address] <= write_data;
         end else begin
            read_data_ff <= mem_ff[address];
         end
      end
   end

   assign read_data = read_data_ff;
endmodule

>>> rtl/core/qvg_slot_ctrl.sv
// ----------------------------------------------------------------------------
// qvg slot control
// size registers, raster counters and slot decode for each accepted word
// ----------------------------------------------------------------------------
module qvg_slot_ctrl
   import qvg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                       accept,
   output slot_type                   slot
);
   logic [SRC_WIDTH_BITS-1:0]  eff_width_ff,  eff_width_in;
   logic [SRC_HEIGHT_BITS-1:0] eff_height_ff, eff_height_in;
   logic [COL_WIDTH-1:0]       last_col_ff,   last_col_in;
   logic [ROW_WIDTH-1:0]       last_row_ff,   last_row_in;
   logic [COL_WIDTH-1:0]       col_ff,        col_in;
   logic [ROW_WIDTH-1:0]       row_ff,        row_in;

   logic [SRC_WIDTH_BITS-1:0]  width_raw;
   logic [SRC_HEIGHT_BITS-1:0] height_raw;
   logic [COL_WIDTH-1:0]       col_cur;
   logic [ROW_WIDTH-1:0]       row_cur;
   logic [COL_WIDTH-1:0]       right_col;

   always_comb begin
      width_raw  = csr_write_data[SRC_WIDTH_BITS-1:0];
      height_raw = csr_write_data[SRC_HEIGHT_BITS-1:0];

      eff_width_in  = eff_width_ff;
      eff_height_in = eff_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH: begin
               if (width_raw == '0) begin
                  eff_width_in = SRC_WIDTH_BITS'(1);
               end else if (int'(width_raw) > MAX_LINE_WIDTH) begin
                  eff_width_in = SRC_WIDTH_BITS'(MAX_LINE_WIDTH);
               end else begin
                  eff_width_in = width_raw;
               end
            end
            CSR_SOURCE_HEIGHT: begin
               eff_height_in = (height_raw == '0) ? SRC_HEIGHT_BITS'(1) : height_raw;
            end
            default: begin
               eff_width_in  = eff_width_ff;
               eff_height_in = eff_height_ff;
            end
         endcase
      end
      last_col_in = {eff_width_in, 1'b0} - COL_WIDTH'(1);
      last_row_in = {eff_height_in, 1'b0} - ROW_WIDTH'(1);

      // out of range counters restart at the origin
      col_cur = (col_ff > last_col_ff) ? '0 : col_ff;
      row_cur = (row_ff > last_row_ff) ? '0 : row_ff;
      right_col = col_cur - COL_WIDTH'(eff_width_ff);

      slot.left        = (col_cur < COL_WIDTH'(eff_width_ff));
      slot.line_addr   = slot.left ? LINE_ADDR_WIDTH'(col_cur) : LINE_ADDR_WIDTH'(right_col);
      slot.frame_start = (col_cur == '0) && (row_cur == '0);
      slot.line_end    = (col_cur == last_col_ff);

      col_in = col_ff;
      row_in = row_ff;
      if (csr_write_enable) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (slot.line_end) begin
            col_in = '0;
            row_in = (row_cur == last_row_ff) ? '0 : row_cur + ROW_WIDTH'(1);
         end else begin
            col_in = col_cur + COL_WIDTH'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_width_ff  <= SRC_WIDTH_BITS'(WIDTH_RESET);
         eff_height_ff <= SRC_HEIGHT_BITS'(HEIGHT_RESET);
         last_col_ff   <= COL_WIDTH'(2 * WIDTH_RESET - 1);
         last_row_ff   <= ROW_WIDTH'(2 * HEIGHT_RESET - 1);
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         eff_width_ff  <= eff_width_in;
         eff_height_ff <= eff_height_in;
         last_col_ff   <= last_col_in;
         last_row_ff   <= last_row_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end
endmodule

>>> rtl/core/qvg_out_stage.sv
// ----------------------------------------------------------------------------
// qvg output stage
// slot register beside the line store read, grey conversion and result register
// ----------------------------------------------------------------------------
module qvg_out_stage
   import qvg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  slot_type               slot,
   input  logic [PIXEL_WIDTH-1:0] pixel,
   input  logic [PIXEL_WIDTH-1:0] store_data,
   output logic                   slot_free,
   output logic                   slot_stalled,
   qvg_rsp_if.source              rsp_bus
);
   localparam int SUM_WIDTH   = CHAN_WIDTH + 2;
   localparam int RECIP_SHIFT = 11;
   localparam int GREY_RECIP  = 683;   // ceil(2^11 / 3), exact for sums up to 765
   localparam int PROD_WIDTH  = SUM_WIDTH + RECIP_SHIFT;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_left_ff;
   logic                   s1_frame_start_ff;
   logic                   s1_line_end_ff;
   logic [PIXEL_WIDTH-1:0] s1_pixel_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_WIDTH-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                   rsp_frame_start_ff;
   logic                   rsp_line_end_ff;

   logic                   out_free;
   logic                   s1_move;
   logic [SUM_WIDTH-1:0]   sum;
   logic [PROD_WIDTH-1:0]  prod;
   logic [CHAN_WIDTH-1:0]  grey;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_bus.ready;
      s1_move      = s1_valid_ff && out_free;
      slot_free    = !s1_valid_ff || out_free;
      slot_stalled = s1_valid_ff && !out_free;

      sum  = SUM_WIDTH'(store_data[CHAN_WIDTH-1:0])
           + SUM_WIDTH'(store_data[2*CHAN_WIDTH-1:CHAN_WIDTH])
           + SUM_WIDTH'(store_data[3*CHAN_WIDTH-1:2*CHAN_WIDTH]);
      prod = PROD_WIDTH'(sum) * PROD_WIDTH'(GREY_RECIP);
      grey = prod[RECIP_SHIFT +: CHAN_WIDTH];

      rsp_pixel_in = s1_left_ff ? s1_pixel_ff : {grey, grey, grey};
      s1_valid_in  = accept || (s1_valid_ff && !out_free);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_left_ff        <= slot.left;
         s1_frame_start_ff <= slot.frame_start;
         s1_line_end_ff    <= slot.line_end;
         s1_pixel_ff       <= pixel;
      end
      if (s1_move) begin
         rsp_pixel_ff       <= rsp_pixel_in;
         rsp_frame_start_ff <= s1_frame_start_ff;
         rsp_line_end_ff    <= s1_line_end_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_chan0   = rsp_pixel_ff[CHAN_WIDTH-1:0];
   assign rsp_bus.out_chan1   = rsp_pixel_ff[2*CHAN_WIDTH-1:CHAN_WIDTH];
   assign rsp_bus.out_chan2   = rsp_pixel_ff[3*CHAN_WIDTH-1:2*CHAN_WIDTH];
   assign rsp_bus.frame_start = rsp_frame_start_ff;
   assign rsp_bus.line_end    = rsp_line_end_ff;
endmodule

>>> bench/tb_quad_view_grey_compositor_unit.sv
// ----------------------------------------------------------------------------
// quad view grey compositor unit testbench
// drives source pixel words into the compositor and checks every result word
// against a cycle-free model of the 2x2 view: pass-through and line capture on
// the left half, floor-of-mean grey on the right half, frame and line flags,
// size register clamping and raster restart on register writes
// ----------------------------------------------------------------------------
module tb_quad_view_grey_compositor_unit;
   import qvg_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_SETTLE  = 8;      // extra quiet cycles after the last owed word
   localparam int IDLE_PERCENT  = 23;
   localparam int RANDOM_WORDS  = 450;
   localparam int STEADY_WORDS  = 300;    // opening stretch of the random part
   localparam int REPORT_LIMIT  = 10;

   // source pixel as carried by one request word
   typedef struct packed {
      logic [CHAN_WIDTH-1:0] chan0;
      logic [CHAN_WIDTH-1:0] chan1;
      logic [CHAN_WIDTH-1:0] chan2;
   } source_pixel_t;

   // one output pixel slot with its framing flags
   typedef struct packed {
      logic [CHAN_WIDTH-1:0] chan0;
      logic [CHAN_WIDTH-1:0] chan1;
      logic [CHAN_WIDTH-1:0] chan2;
      logic                  frame_start;
      logic                  line_end;
   } view_word_t;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   qvg_req_if req_bus ();
   qvg_rsp_if rsp_bus ();

   quad_view_grey_compositor_unit uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   // 8 unit period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // view model state: size registers, raster position and the captured line
   logic [SRC_WIDTH_BITS-1:0]  size_width;
   logic [SRC_HEIGHT_BITS-1:0] size_height;
   int unsigned                raster_col;
   int unsigned                raster_row;
   source_pixel_t              line_copy [MAX_LINE_WIDTH];

   // result words owed by the unit, oldest first
   view_word_t pending_views [$];

   // run bookkeeping
   int  cycle_count    = 0;
   int  fail_count     = 0;
   int  words_sent     = 0;
   int  words_checked  = 0;
   int  grey_words     = 0;
   int  frames_seen    = 0;
   int  size_writes    = 0;
   bit  steady_flow    = 1'b0;   // both sides free-running when set

   // ---------------------------------------------------------------------------
   // view model
   // ---------------------------------------------------------------------------

   // register write: width keeps its low ten bits, any write restarts the raster
   function automatic void apply_size_write(logic [CSR_INDEX_WIDTH-1:0] index,
                                            logic [CSR_DATA_WIDTH-1:0]  data);
      if (index == CSR_SOURCE_WIDTH) begin
         size_width = data[SRC_WIDTH_BITS-1:0];
      end else if (index == CSR_SOURCE_HEIGHT) begin
         size_height = data[SRC_HEIGHT_BITS-1:0];
      end
      raster_col = 0;
      raster_row = 0;
   endfunction

   // work out the result word of one slot and step the raster
   function automatic view_word_t compose_view_word(source_pixel_t px);
      int unsigned   w;
      int unsigned   h;
      int unsigned   col;
      int unsigned   row;
      int unsigned   grey;
      source_pixel_t kept;
      view_word_t    word;
      // zero sizes act as one, width is held to the line store
      w = (size_width == 0) ? 1 : ((size_width > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : size_width);
      h = (size_height == 0) ? 1 : size_height;
      col = raster_col;
      row = raster_row;
      if (col >= 2 * w) col = 0;
      if (row >= 2 * h) row = 0;
      if (col < w) begin
         line_copy[col] = px;
         word.chan0 = px.chan0;
         word.chan1 = px.chan1;
         word.chan2 = px.chan2;
      end else begin
         kept = line_copy[col - w];
         grey = (int'(kept.chan0) + int'(kept.chan1) + int'(kept.chan2)) / 3;
         word.chan0 = CHAN_WIDTH'(grey);
         word.chan1 = CHAN_WIDTH'(grey);
         word.chan2 = CHAN_WIDTH'(grey);
      end
      word.frame_start = (row == 0) && (col == 0);
      word.line_end    = (col == 2 * w - 1);
      if (word.line_end) begin
         col = 0;
         row = (row == 2 * h - 1) ? 0 : row + 1;
      end else begin
         col = col + 1;
      end
      raster_col = col;
      raster_row = row;
      return word;
   endfunction

   // ---------------------------------------------------------------------------
   // monitor and checker: all sampling at the rising edge, before any update
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      view_word_t got;
      view_word_t want;
      if (reset) begin
         size_width  = SRC_WIDTH_BITS'(WIDTH_RESET);
         size_height = SRC_HEIGHT_BITS'(HEIGHT_RESET);
         raster_col  = 0;
         raster_row  = 0;
         pending_views.delete();
      end else begin
         // result side first, the unit never answers within the same cycle
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.out_chan0, rsp_bus.out_chan1, rsp_bus.out_chan2,
                    rsp_bus.frame_start, rsp_bus.line_end};
            if (pending_views.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("[%0d] unexpected result word %h with nothing owed",
                           cycle_count, got);
            end else begin
               want = pending_views.pop_front();
               words_checked++;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display({"[%0d] word %0d mismatch: chan %h/%h/%h fs %b le %b,",
                               " expected chan %h/%h/%h fs %b le %b"},
                              cycle_count, words_checked,
                              got.chan0, got.chan1, got.chan2, got.frame_start,
                              got.line_end, want.chan0, want.chan1, want.chan2,
                              want.frame_start, want.line_end);
               end
            end
         end
         // size writes only land while the request side is quiet
         if (csr_write_enable) begin
            apply_size_write(csr_index, csr_write_data);
            size_writes++;
         end
         if (req_bus.valid && req_bus.ready) begin
            want = compose_view_word('{req_bus.in_chan0, req_bus.in_chan1,
                                       req_bus.in_chan2});
            pending_views.push_back(want);
            if (want.frame_start) frames_seen++;
         end
      end
   end

   // grey words are those with all three channels equal, as every right-half slot has
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready && rsp_bus.out_chan0 == rsp_bus.out_chan1
          && rsp_bus.out_chan1 == rsp_bus.out_chan2)
         grey_words++;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // hard stop in case the unit hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[%0d] timed out with %0d words still owed", cycle_count,
                  pending_views.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // shared driving tasks, each entered just after a rising edge
   // ---------------------------------------------------------------------------

   // offer one source word, with random gaps in front, and wait for acceptance
   task automatic send_pixel(source_pixel_t px);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.in_chan0 <= px.chan0;
      req_bus.in_chan1 <= px.chan1;
      req_bus.in_chan2 <= px.chan2;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
   endtask

   // channel values lean towards the rails now and then
   function automatic logic [CHAN_WIDTH-1:0] random_chan();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return CHAN_WIDTH'($urandom);
      endcase
   endfunction

   function automatic source_pixel_t random_pixel();
      return '{random_chan(), random_chan(), random_chan()};
   endfunction

   task automatic send_random_pixels(int count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // stop offering words and wait until every owed result has come back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_views.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   // one register write, after which the port is left quiet before the task returns
   task automatic write_size(logic [CSR_INDEX_WIDTH-1:0] index, int unsigned value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= CSR_DATA_WIDTH'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_view_size(int unsigned width, int unsigned height);
      write_size(CSR_SOURCE_WIDTH, width);
      write_size(CSR_SOURCE_HEIGHT, height);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // reset sizes untouched: the opening slots of the first line pass straight
   // through, the first flags the frame start and none carries a line end
   task automatic test_reset_geometry();
      send_random_pixels(16);
      wait_for_drain();
   endtask

   // rail values and rounding of the grey mean on a 4 x 1 source
   task automatic test_pixel_extremes();
      source_pixel_t camera_a [4] = '{24'h000000, 24'hFFFFFF, 24'h010100, 24'h020201};
      source_pixel_t camera_b [4] = '{24'hFFFFFE, 24'hAA55AA, 24'h55AA55, 24'h0000FF};
      set_view_size(4, 1);
      foreach (camera_a[i]) send_pixel(camera_a[i]);
      // right-half data is ignored, feed it opposite patterns
      send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'h55AA55);
      send_pixel(24'hAA55AA);
      foreach (camera_b[i]) send_pixel(camera_b[i]);
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hAA55AA);
      send_pixel(24'h55AA55);
      // frame wraps back to the top
      send_random_pixels(2);
      wait_for_drain();
   endtask

   // zero sizes, width beyond the store, top bit of the width write ignored,
   // tallest height register values
   task automatic test_size_extremes();
      set_view_size(0, 0);
      send_random_pixels(12);
      wait_for_drain();
      // 1023 must clamp to 640: the grey half starts at slot 640
      set_view_size(1023, 1);
      send_random_pixels(MAX_LINE_WIDTH + 4);
      wait_for_drain();
      set_view_size(1, 2047);
      send_random_pixels(20);
      wait_for_drain();
      set_view_size(2, 1080);
      send_random_pixels(12);
      wait_for_drain();
      // bit ten set on a width write, only the low ten bits count
      set_view_size(12'h402, 1);
      send_random_pixels(10);
      wait_for_drain();
      set_view_size(MAX_LINE_WIDTH, 1);
      send_random_pixels(4);
      wait_for_drain();
   endtask

   // any size write restarts the raster mid-frame, rewriting the same value too
   task automatic test_restart_on_write();
      set_view_size(3, 2);
      send_random_pixels(8);
      wait_for_drain();
      write_size(CSR_SOURCE_HEIGHT, 2);
      send_random_pixels(30);
      wait_for_drain();
      write_size(CSR_SOURCE_WIDTH, 5);
      send_random_pixels(3);
      wait_for_drain();
      write_size(CSR_SOURCE_WIDTH, 5);
      send_random_pixels(25);
      wait_for_drain();
   endtask

   // random small views, whole frames most of the time, stray partial runs and
   // odd register writes the rest; the opening stretch runs without idling
   task automatic test_random_views();
      int          sent;
      int unsigned width;
      int unsigned height;
      int          frame_slots;
      int          count;
      sent = 0;
      steady_flow = 1'b1;
      while (sent < RANDOM_WORDS) begin
         if (sent >= STEADY_WORDS) steady_flow = 1'b0;
         case ($urandom_range(0, 9))
            0:       width = $urandom_range(9, 24);
            1:       width = 0;
            default: width = $urandom_range(1, 8);
         endcase
         height = $urandom_range(0, 3);
         frame_slots = 4 * (width == 0 ? 1 : width) * (height == 0 ? 1 : height);
         // stray top bits on the width write now and then
         if ($urandom_range(0, 4) == 0) width = width | 32'h400;
         case ($urandom_range(0, 5))
            0:       write_size(CSR_SOURCE_WIDTH, width);
            1:       write_size(CSR_SOURCE_HEIGHT, height);
            default: begin
               if ($urandom_range(0, 1)) begin
                  set_view_size(width, height);
               end else begin
                  write_size(CSR_SOURCE_HEIGHT, height);
                  write_size(CSR_SOURCE_WIDTH, width);
               end
            end
         endcase
         if ($urandom_range(0, 3) != 0)
            count = frame_slots * $urandom_range(1, 2) + $urandom_range(0, 2);
         else
            count = $urandom_range(1, frame_slots + 3);
         if (count > RANDOM_WORDS - sent) count = RANDOM_WORDS - sent;
         send_random_pixels(count);
         sent += count;
         wait_for_drain();
      end
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_SOURCE_WIDTH;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.in_chan0 <= '0;
      req_bus.in_chan1 <= '0;
      req_bus.in_chan2 <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_geometry();
      test_pixel_extremes();
      test_size_extremes();
      test_restart_on_write();
      test_random_views();
      wait_for_drain();

      if (pending_views.size() != 0) begin
         fail_count++;
         $display("%0d result words never arrived", pending_views.size());
      end
      $display("covered %0d source words over %0d frame starts and %0d size writes",
               words_sent, frames_seen, size_writes);
      $display("checked %0d result words (%0d grey-level), %0d failures",
               words_checked, grey_words, fail_count);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
